// ===== hdl/slx_pkg.sv =====
// Shared types, codes and character classing for the script lexer token classifier.
package slx_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_WORD   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_FINISHED = 4'd0,
    KIND_EOL      = 4'd1,
    KIND_DELIM    = 4'd2,
    KIND_QUOTED   = 4'd3,
    KIND_NUMBER   = 4'd4,
    KIND_VARIABLE = 4'd5,
    KIND_COMMAND  = 4'd6,
    KIND_ERROR    = 4'd7,
    KIND_UNKNOWN  = 4'd8
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_present;
    kind_t      token_kind;
    logic       token_done;
  } tok_rec_t;

  // What one byte does when no token is open.
  typedef struct packed {
    logic     has_rec;
    tok_rec_t rec;
    mode_t    mode;
    logic     word_start;
  } idle_res_t;

  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    unique case (c)
      8'h00, 8'h09, 8'h0A, 8'h20,
      ";", ",", "+", "-", "<", ">", "/", "*", "%", "^", "=", "(",
      ")", "|", "&", "~": d = 1'b1;
      default:            d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic tok_rec_t mk_rec(input logic [7:0] b, input logic p,
                                      input kind_t k, input logic d);
    tok_rec_t r;
    r.token_byte   = b;
    r.byte_present = p;
    r.token_kind   = k;
    r.token_done   = d;
    return r;
  endfunction

  function automatic idle_res_t from_idle(input logic [7:0] c);
    idle_res_t r;
    r.has_rec    = 1'b1;
    r.mode       = MODE_IDLE;
    r.word_start = 1'b0;
    r.rec        = mk_rec(c, 1'b1, KIND_UNKNOWN, 1'b1);
    priority if (c == CH_SPACE || c == CH_TAB) begin
      r.has_rec = 1'b0;
    end else if (c == CH_NUL) begin
      r.rec = mk_rec(8'h00, 1'b0, KIND_FINISHED, 1'b1);
    end else if (c == CH_NL) begin
      r.rec = mk_rec(c, 1'b1, KIND_EOL, 1'b1);
    end else if (is_delim(c)) begin
      r.rec = mk_rec(c, 1'b1, KIND_DELIM, 1'b1);
    end else if (c == CH_QUOTE) begin
      r.has_rec = 1'b0;
      r.mode    = MODE_QUOTE;
    end else if (c >= "0" && c <= "9") begin
      r.mode = MODE_NUMBER;
      r.rec  = mk_rec(c, 1'b1, KIND_NUMBER, 1'b0);
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      r.mode       = MODE_WORD;
      r.word_start = 1'b1;
      r.rec        = mk_rec(c, 1'b1, KIND_VARIABLE, 1'b0);
    end else begin
      r.rec = mk_rec(c, 1'b1, KIND_UNKNOWN, 1'b1);
    end
    return r;
  endfunction

endpackage

// ===== hdl/slx_in_if.sv =====
// Valid/ready channel carrying one byte of program text per beat.
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== hdl/slx_out_if.sv =====
// Valid/ready channel carrying one token record per beat.
interface slx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       byte_present;
  logic [3:0] token_kind;
  logic       token_done;

  modport source (output valid, output token_byte, output byte_present,
                  output token_kind, output token_done, input ready);
  modport sink   (input valid, input token_byte, input byte_present,
                  input token_kind, input token_done, output ready);
endinterface

// ===== hdl/script_lexer_token_classifier_core.sv =====
// Top level: byte-stream lexer that emits classified token records.
//
//  channel | dir | payload                                          | beat
//  --------+-----+--------------------------------------------------+-----------------------
//  text    | in  | text_byte[7:0]                                   | one program byte
//  token   | out | token_byte[7:0] byte_present token_kind[3:0] done | one token record
//
// One byte per cycle while the token side takes one record per cycle and the text
// averages no more than one record per byte; a token boundary costs a second record.
// A byte is captured, then classified against the scan state, and when the stage advances its
// zero to two records land in a 4-entry queue, offered from the cycle after that.
// The input stage advances only while the queue has room for two records after
// this cycle's pop, so output stalls back up into text.ready.
// rst (sync, active high) clears the scan state, input stage and queue.
module script_lexer_token_classifier_core (
  input logic clk,
  input logic rst,
  slx_in_if.sink    text,
  slx_out_if.source token
);
  import slx_pkg::*;

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  mode_t                 mode, mode_next;
  logic [1:0]            word_len, word_len_next;

  tok_rec_t              fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr, rd_ptr;
  logic [FIFO_AW:0]      count;

  logic                  pop, advance, in_take;
  logic [FIFO_AW:0]      occ_after_pop;
  logic [1:0]            n_rec;
  tok_rec_t              r0, r1;
  idle_res_t             idl;
  kind_t                 word_kind;
  tok_rec_t              head;

  assign pop           = token.valid && token.ready;
  assign occ_after_pop = count - {{FIFO_AW{1'b0}}, pop};
  assign advance       = s1_valid && (occ_after_pop <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign text.ready    = !s1_valid || advance;
  assign in_take       = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_byte <= text.text_byte;
    end
  end

  // Classification of the staged byte.
  always_comb begin
    idl           = from_idle(s1_byte);
    word_kind     = (word_len >= 2'd2) ? KIND_COMMAND : KIND_VARIABLE;
    mode_next     = mode;
    word_len_next = word_len;
    n_rec         = 2'd0;
    r0            = idl.rec;
    r1            = idl.rec;
    unique case (mode)
      MODE_QUOTE: begin
        if (s1_byte == CH_QUOTE) begin
          mode_next = MODE_IDLE;
          r0        = mk_rec(8'h00, 1'b0, KIND_QUOTED, 1'b1);
          n_rec     = 2'd1;
        end else if (s1_byte == CH_NL || s1_byte == CH_NUL) begin
          // unterminated string: error close, then the byte as its own token
          mode_next = idl.mode;
          r0        = mk_rec(8'h00, 1'b0, KIND_ERROR, 1'b1);
          n_rec     = {idl.has_rec, !idl.has_rec};
        end else begin
          r0    = mk_rec(s1_byte, 1'b1, KIND_QUOTED, 1'b0);
          n_rec = 2'd1;
        end
      end
      MODE_NUMBER: begin
        if (is_delim(s1_byte)) begin
          mode_next = idl.mode;
          r0        = mk_rec(8'h00, 1'b0, KIND_NUMBER, 1'b1);
          n_rec     = {idl.has_rec, !idl.has_rec};
        end else begin
          r0    = mk_rec(s1_byte, 1'b1, KIND_NUMBER, 1'b0);
          n_rec = 2'd1;
        end
      end
      MODE_WORD: begin
        if (is_delim(s1_byte)) begin
          mode_next     = idl.mode;
          word_len_next = 2'd0;
          r0            = mk_rec(8'h00, 1'b0, word_kind, 1'b1);
          n_rec         = {idl.has_rec, !idl.has_rec};
        end else begin
          word_len_next = 2'd2;
          r0            = mk_rec(s1_byte, 1'b1, KIND_COMMAND, 1'b0);
          n_rec         = 2'd1;
        end
      end
      default: begin
        mode_next = idl.mode;
        if (idl.word_start) begin
          word_len_next = 2'd1;
        end
        r0    = idl.rec;
        n_rec = {1'b0, idl.has_rec};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      word_len <= 2'd0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (advance) begin
        mode     <= mode_next;
        word_len <= word_len_next;
        wr_ptr   <= wr_ptr + FIFO_AW'(n_rec);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (advance ? {{(FIFO_AW-1){1'b0}}, n_rec} : '0)
                     - {{FIFO_AW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (advance && n_rec != 2'd0) begin
      fifo[wr_ptr] <= r0;
    end
    if (advance && n_rec == 2'd2) begin
      fifo[wr_ptr + 1'b1] <= r1;
    end
  end

  assign head               = fifo[rd_ptr];
  assign token.valid        = (count != '0);
  assign token.token_byte   = head.token_byte;
  assign token.byte_present = head.byte_present;
  assign token.token_kind   = head.token_kind;
  assign token.token_done   = head.token_done;

endmodule

// ===== hdl/slx_checker.sv =====
// Port-level checks for the lexer core, bound to the top level.
module slx_checker (
  input logic       clk,
  input logic       rst,
  input logic       tok_valid,
  input logic       tok_ready,
  input logic [7:0] tok_byte,
  input logic       tok_present,
  input logic [3:0] tok_kind,
  input logic       tok_done
);
  import slx_pkg::*;

  // stalled beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token beat dropped while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !tok_valid)
    else $error("token valid right after reset");

  // a record with no byte always closes its token
  a_close: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_present |-> tok_done && tok_byte == 8'h00)
    else $error("byteless record not a close");

  // open records carry a byte and a kind that can continue
  a_open: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_done |-> tok_present &&
      (tok_kind == KIND_QUOTED || tok_kind == KIND_NUMBER ||
       tok_kind == KIND_VARIABLE || tok_kind == KIND_COMMAND))
    else $error("open record with terminal kind");

  a_finished: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == KIND_FINISHED |-> !tok_present && tok_done)
    else $error("finished record malformed");

endmodule

bind script_lexer_token_classifier_core slx_checker u_slx_checker (
  .clk         (clk),
  .rst         (rst),
  .tok_valid   (token.valid),
  .tok_ready   (token.ready),
  .tok_byte    (token.token_byte),
  .tok_present (token.byte_present),
  .tok_kind    (token.token_kind),
  .tok_done    (token.token_done)
);

// ===== bench/slx_lexer_checker.sv =====
// Token checker: watches both channels, predicts the lexer's records and compares them.
`timescale 1ns / 1ps

module slx_lexer_checker (
  input  logic clk,
  input  logic rst,
  slx_in_if    text,
  slx_out_if   token,
  output int   error_count,
  output int   pending_count
);
  import slx_pkg::*;

  tok_rec_t   expected_tokens[$];
  mode_t      lex_mode;
  logic [1:0] letters_seen;
  int         mismatches  = 0;
  int         outstanding = 0;

  assign error_count   = mismatches;
  assign pending_count = outstanding;

  function automatic logic is_separator(input logic [7:0] c);
    string seps;
    logic  hit;
    seps = " ;,+-<>/*%^=()|&~";
    hit  = (c == CH_NUL) || (c == CH_TAB) || (c == CH_NL);
    for (int i = 0; i < seps.len(); i++)
      if (c == seps[i]) hit = 1'b1;
    return hit;
  endfunction

  task automatic add_token(input logic [7:0] b, input logic p, input kind_t k,
                           input logic d);
    tok_rec_t t;
    t.token_byte   = b;
    t.byte_present = p;
    t.token_kind   = k;
    t.token_done   = d;
    expected_tokens.push_back(t);
  endtask

  // Byte seen with no token open.
  task automatic lex_idle(input logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == CH_SPACE || c == CH_TAB) begin
    end else if (c == CH_NUL) begin
      add_token(8'h00, 1'b0, KIND_FINISHED, 1'b1);
    end else if (c == CH_NL) begin
      add_token(c, 1'b1, KIND_EOL, 1'b1);
    end else if (is_separator(c)) begin
      add_token(c, 1'b1, KIND_DELIM, 1'b1);
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_QUOTE;
    end else if (c >= "0" && c <= "9") begin
      lex_mode = MODE_NUMBER;
      add_token(c, 1'b1, KIND_NUMBER, 1'b0);
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      lex_mode     = MODE_WORD;
      letters_seen = 2'd1;
      add_token(c, 1'b1, KIND_VARIABLE, 1'b0);
    end else begin
      add_token(c, 1'b1, KIND_UNKNOWN, 1'b1);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    kind_t k;
    case (lex_mode)
      MODE_QUOTE: begin
        if (c == CH_QUOTE) begin
          lex_mode = MODE_IDLE;
          add_token(8'h00, 1'b0, KIND_QUOTED, 1'b1);
        end else if (c == CH_NL || c == CH_NUL) begin
          // unterminated string: error close, then the byte as if idle
          add_token(8'h00, 1'b0, KIND_ERROR, 1'b1);
          lex_idle(c);
        end else begin
          add_token(c, 1'b1, KIND_QUOTED, 1'b0);
        end
      end
      MODE_NUMBER: begin
        if (is_separator(c)) begin
          add_token(8'h00, 1'b0, KIND_NUMBER, 1'b1);
          lex_idle(c);
        end else begin
          add_token(c, 1'b1, KIND_NUMBER, 1'b0);
        end
      end
      MODE_WORD: begin
        if (is_separator(c)) begin
          k = (letters_seen >= 2'd2) ? KIND_COMMAND : KIND_VARIABLE;
          letters_seen = 2'd0;
          add_token(8'h00, 1'b0, k, 1'b1);
          lex_idle(c);
        end else begin
          letters_seen = 2'd2;
          add_token(c, 1'b1, KIND_COMMAND, 1'b0);
        end
      end
      default: lex_idle(c);
    endcase
  endtask

  always @(posedge clk) begin : monitor
    tok_rec_t want;
    if (rst) begin
      lex_mode     = MODE_IDLE;
      letters_seen = 2'd0;
      expected_tokens.delete();
    end else begin
      if (token.valid && token.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected beat byte=%02h present=%0d kind=%0d done=%0d",
                     $realtime, token.token_byte, token.byte_present,
                     token.token_kind, token.token_done);
        end else begin
          want = expected_tokens.pop_front();
          if (token.token_byte !== want.token_byte ||
              token.byte_present !== want.byte_present ||
              token.token_kind !== want.token_kind ||
              token.token_done !== want.token_done) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: exp byte=%02h present=%0d kind=%0d done=%0d, got byte=%02h present=%0d kind=%0d done=%0d",
                       $realtime, want.token_byte, want.byte_present,
                       want.token_kind, want.token_done, token.token_byte,
                       token.byte_present, token.token_kind, token.token_done);
          end
        end
      end
      if (text.valid && text.ready)
        lex_byte(text.text_byte);
    end
    outstanding <= expected_tokens.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the lexer bench: clock, reset, byte stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import slx_pkg::*;

  localparam int ITEM_COUNT   = 1950;
  localparam int MAX_CYCLES   = 400000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 23;
  int   snk_idle = 73;
  int   cycles   = 0;
  int   sent     = 0;
  int   fails;
  int   pending;

  logic [7:0] directed_text [24] = '{
    "A", CH_SPACE, CH_QUOTE, "z", CH_QUOTE, "0", "7", ";",
    "x", "y", CH_NL, CH_QUOTE, 8'hFF, CH_NUL, "9", CH_TAB,
    8'h80, "~", CH_QUOTE, CH_NL, "q", CH_NUL, "@", CH_TAB
  };

  slx_in_if  text_ch ();
  slx_out_if token_ch ();

  script_lexer_token_classifier_core uut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .token (token_ch)
  );

  slx_lexer_checker chk (
    .clk           (clk),
    .rst           (rst),
    .text          (text_ch),
    .token         (token_ch),
    .error_count   (fails),
    .pending_count (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    token_ch.ready <= ($urandom_range(0, 99) >= snk_idle);

  // Called right after a falling edge; returns right after a falling edge, once the byte has been taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0)
      return 8'h41 + 8'($urandom_range(0, 25));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_separator();
    string punct;
    int    r;
    punct = " ;,+-<>/*%^=()|&~";
    r = $urandom_range(0, 99);
    if (r < 70) return punct[$urandom_range(0, punct.len() - 1)];
    if (r < 80) return CH_TAB;
    if (r < 95) return CH_NL;
    return CH_NUL;
  endfunction

  // One mostly well-formed token, sometimes noise.
  task automatic send_token();
    int         r;
    int         n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) c = rand_letter();
        else c = 8'h30 + 8'($urandom_range(0, 9));
        send_byte(c);
      end
      if ($urandom_range(0, 4) != 0) send_byte(rand_separator());
    end else if (r < 45) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 6) == 0) c = 8'($urandom_range(128, 255));
        else if (i > 0 && $urandom_range(0, 6) == 0) c = 8'h30 + 8'($urandom_range(0, 9));
        else c = rand_letter();
        send_byte(c);
      end
      if ($urandom_range(0, 4) != 0) send_byte(rand_separator());
    end else if (r < 60) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_NL);
        send_byte(c);
      end
      if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
      else if ($urandom_range(0, 1) == 0) send_byte(CH_NL);
      else send_byte(CH_NUL);
    end else if (r < 80) begin
      send_byte(rand_separator());
    end else if (r < 85) begin
      send_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
    end else if (r < 90) begin
      send_byte(CH_NL);
    end else if (r < 92) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold off the sender until every expected record is out, then let the pipe drain.
  task automatic quiesce();
    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int ph;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_text[i]) send_byte(directed_text[i]);
    quiesce();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle = 23; snk_idle = 73; end
        1: begin src_idle = 73; snk_idle = 23; end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      while (sent < 24 + (ph + 1) * ITEM_COUNT / 3) send_token();
      quiesce();
    end

    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
